// ===== rtl/mac_pkg.sv =====
// ----------------------------------------------------------------------------
// mac_pkg
// Shared types and codes for the minicomputer ALU: opcodes, flag bit
// positions and the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package mac_pkg;

    localparam int WORD_W  = 16;
    localparam int OP_W    = 6;
    localparam int FLAGS_W = 4;
    localparam int DIV_STEPS = 32;
    localparam int CNT_W   = 6;

    localparam logic [OP_W-1:0] OP_CLR  = 6'd0;
    localparam logic [OP_W-1:0] OP_COM  = 6'd1;
    localparam logic [OP_W-1:0] OP_INC  = 6'd2;
    localparam logic [OP_W-1:0] OP_DEC  = 6'd3;
    localparam logic [OP_W-1:0] OP_NEG  = 6'd4;
    localparam logic [OP_W-1:0] OP_TST  = 6'd5;
    localparam logic [OP_W-1:0] OP_ASR  = 6'd6;
    localparam logic [OP_W-1:0] OP_ASL  = 6'd7;
    localparam logic [OP_W-1:0] OP_ROR  = 6'd8;
    localparam logic [OP_W-1:0] OP_ROL  = 6'd9;
    localparam logic [OP_W-1:0] OP_SWAB = 6'd10;
    localparam logic [OP_W-1:0] OP_ADC  = 6'd11;
    localparam logic [OP_W-1:0] OP_SBC  = 6'd12;
    localparam logic [OP_W-1:0] OP_SXT  = 6'd13;
    localparam logic [OP_W-1:0] OP_MOV  = 6'd14;
    localparam logic [OP_W-1:0] OP_CMP  = 6'd15;
    localparam logic [OP_W-1:0] OP_ADD  = 6'd16;
    localparam logic [OP_W-1:0] OP_SUB  = 6'd17;
    localparam logic [OP_W-1:0] OP_BIT  = 6'd18;
    localparam logic [OP_W-1:0] OP_BIC  = 6'd19;
    localparam logic [OP_W-1:0] OP_BIS  = 6'd20;
    localparam logic [OP_W-1:0] OP_XOR  = 6'd21;
    localparam logic [OP_W-1:0] OP_MUL  = 6'd22;
    localparam logic [OP_W-1:0] OP_DIV  = 6'd23;
    localparam logic [OP_W-1:0] OP_ASH  = 6'd24;
    localparam logic [OP_W-1:0] OP_ASHC = 6'd25;
    localparam logic [OP_W-1:0] OP_CCC  = 6'd26;
    localparam logic [OP_W-1:0] OP_SCC  = 6'd27;
    localparam logic [OP_W-1:0] OP_BR   = 6'd28;
    localparam logic [OP_W-1:0] OP_BNE  = 6'd29;
    localparam logic [OP_W-1:0] OP_BEQ  = 6'd30;
    localparam logic [OP_W-1:0] OP_BPL  = 6'd31;
    localparam logic [OP_W-1:0] OP_BMI  = 6'd32;
    localparam logic [OP_W-1:0] OP_BVC  = 6'd33;
    localparam logic [OP_W-1:0] OP_BVS  = 6'd34;
    localparam logic [OP_W-1:0] OP_BCC  = 6'd35;
    localparam logic [OP_W-1:0] OP_BCS  = 6'd36;
    localparam logic [OP_W-1:0] OP_BGE  = 6'd37;
    localparam logic [OP_W-1:0] OP_BLT  = 6'd38;
    localparam logic [OP_W-1:0] OP_BGT  = 6'd39;
    localparam logic [OP_W-1:0] OP_BLE  = 6'd40;
    localparam logic [OP_W-1:0] OP_BHI  = 6'd41;
    localparam logic [OP_W-1:0] OP_BLOS = 6'd42;

    localparam int FN = 3;
    localparam int FZ = 2;
    localparam int FV = 1;
    localparam int FC = 0;

    typedef struct packed {
        logic load;      // capture input item
        logic exec;      // compute non-divide op / finish divide into output
        logic div_start; // load divider
        logic div_step;  // one restoring step
        logic out_take;  // output accepted
    } mac_cmd_t;

    typedef struct packed {
        logic is_div;
        logic out_full;
    } mac_sts_t;

endpackage

// ===== rtl/mac_datapath.sv =====
// ----------------------------------------------------------------------------
// mac_datapath
// Operand registers, combinational ALU, bit-serial signed divider, condition
// code register and output register.
// ----------------------------------------------------------------------------
module mac_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mac_pkg::mac_cmd_t           cmd,
    output mac_pkg::mac_sts_t           sts,
    input  logic [5:0]                  s_op,
    input  logic                        s_byte_mode,
    input  logic [15:0]                 s_src,
    input  logic [15:0]                 s_dst,
    input  logic [15:0]                 s_dst_low,
    output logic [15:0]                 m_result,
    output logic [15:0]                 m_result_low,
    output logic                        m_write_result,
    output logic                        m_write_low,
    output logic [3:0]                  m_flags,
    output logic                        m_branch_taken
);
    import mac_pkg::*;

    logic [OP_W-1:0]  op_reg;
    logic             bm_reg;
    logic [15:0]      src_reg, dst_reg, dl_reg;
    logic [3:0]       cc_reg, cc_next;
    logic             full_reg;

    logic [31:0]      rem_reg, rem_next;   // magnitude shift register (dividend)
    logic [16:0]      acc_reg, acc_next;   // partial remainder
    logic [15:0]      dvs_reg;             // divisor magnitude

    logic [15:0] r, rl;
    logic        wr, wl, br;
    logic        bf;
    logic [15:0] m, h, ds, ss, t;
    logic [16:0] sum17;
    logic [31:0] prod, x;
    logic [4:0]  n;
    logic [5:0]  c6;
    logic [15:0] mk;
    logic        cin, fn, fz, fv, fc;
    logic [31:0] qmag;
    logic [15:0] rmag, q16, r16;
    logic        qneg, rneg, qovf;
    logic [17:0] acc_sub;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_op;
            bm_reg  <= s_byte_mode;
            src_reg <= s_src;
            dst_reg <= s_dst;
            dl_reg  <= s_dst_low;
        end
    end

    // Restoring divide on magnitudes, one quotient bit per step.
    always_comb begin
        acc_sub  = {acc_reg, rem_reg[31]} - {2'b00, dvs_reg};
        acc_next = acc_reg;
        rem_next = rem_reg;
        if (cmd.div_start) begin
            acc_next = '0;
            rem_next = dst_reg[15] ? (32'd0 - {dst_reg, dl_reg}) : {dst_reg, dl_reg};
        end else if (cmd.div_step) begin
            if (!acc_sub[17]) begin
                acc_next = acc_sub[16:0];
                rem_next = {rem_reg[30:0], 1'b1};
            end else begin
                acc_next = {acc_reg[15:0], rem_reg[31]};
                rem_next = {rem_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            dvs_reg <= src_reg[15] ? (16'd0 - src_reg) : src_reg;
        end
        rem_reg <= rem_next;
        acc_reg <= acc_next;
    end

    always_comb begin
        bf = bm_reg && (((op_reg <= OP_SBC) && (op_reg != OP_SWAB)) || op_reg == OP_MOV ||
             op_reg == OP_CMP || op_reg == OP_BIT || op_reg == OP_BIC || op_reg == OP_BIS);
        m  = bf ? 16'h00FF : 16'hFFFF;
        h  = bf ? 16'h0080 : 16'h8000;
        ds = dst_reg & m;
        ss = src_reg & m;
        cin = cc_reg[FC];
        fn = cc_reg[FN]; fz = cc_reg[FZ]; fv = cc_reg[FV]; fc = cc_reg[FC];
        r = '0; rl = '0; wr = 1'b1; wl = 1'b0; br = 1'b0;
        cc_next = cc_reg;
        t = '0; sum17 = '0; x = '0; n = '0; mk = '0;
        c6 = src_reg[5:0];
        prod = 32'($signed(dst_reg)) * 32'($signed(src_reg));
        qmag = rem_reg;
        rmag = acc_reg[15:0];
        qneg = dst_reg[15] ^ src_reg[15];
        rneg = dst_reg[15];
        q16  = qneg ? (16'd0 - qmag[15:0]) : qmag[15:0];
        r16  = rneg ? (16'd0 - rmag) : rmag;
        qovf = qneg ? (qmag > 32'h8000) : (qmag > 32'h7FFF);
        case (op_reg)
            OP_CLR: cc_next = 4'b0100;
            OP_COM: begin
                r = ~ds & m;
                cc_next = {|(r & h), ~|(r & m), 2'b01};
            end
            OP_INC: begin
                r = (ds + 16'd1) & m;
                cc_next = {|(r & h), ~|(r & m), ds == (h - 16'd1), fc};
            end
            OP_DEC: begin
                r = (ds - 16'd1) & m;
                cc_next = {|(r & h), ~|(r & m), ds == h, fc};
            end
            OP_NEG: begin
                r = (16'd0 - ds) & m;
                cc_next = {|(r & h), ~|(r & m), r == h, r != 16'd0};
            end
            OP_TST: begin
                wr = 1'b0;
                cc_next = {|(ds & h), ~|ds, 2'b00};
            end
            OP_ASR, OP_ASL, OP_ROR, OP_ROL: begin
                unique case (op_reg)
                    OP_ASR: begin r = (ds >> 1) | (ds & h); cc_next[FC] = ds[0]; end
                    OP_ASL: begin r = (ds << 1) & m; cc_next[FC] = |(ds & h); end
                    OP_ROR: begin r = (ds >> 1) | (cin ? h : 16'd0); cc_next[FC] = ds[0]; end
                    default: begin
                        r = ((ds << 1) & m) | {15'd0, cin};
                        cc_next[FC] = |(ds & h);
                    end
                endcase
                cc_next[FN] = |(r & h);
                cc_next[FZ] = ~|(r & m);
                cc_next[FV] = cc_next[FN] ^ cc_next[FC];
            end
            OP_SWAB: begin
                r = {dst_reg[7:0], dst_reg[15:8]};
                cc_next = {r[7], r[7:0] == 8'd0, 2'b00};
            end
            OP_ADC: begin
                r = (ds + {15'd0, cin}) & m;
                cc_next = {|(r & h), ~|(r & m), (ds == h - 16'd1) && cin, (ds == m) && cin};
            end
            OP_SBC: begin
                r = (ds - {15'd0, cin}) & m;
                cc_next = {|(r & h), ~|(r & m), ds == h, (ds == 16'd0) && cin};
            end
            OP_SXT: begin
                r = fn ? 16'hFFFF : 16'h0000;
                cc_next = {fn, ~fn, 1'b0, fc};
            end
            OP_MOV: begin
                r = bf ? {{8{ss[7]}}, ss[7:0]} : src_reg;
                cc_next = {|(ss & h), ~|ss, 1'b0, fc};
            end
            OP_CMP: begin
                wr = 1'b0;
                t = (ss - ds) & m;
                cc_next = {|(t & h), ~|t, (|((ss ^ ds) & h)) && !(|((ds ^ t) & h)), ss < ds};
            end
            OP_ADD: begin
                sum17 = {1'b0, src_reg} + {1'b0, dst_reg};
                r = sum17[15:0];
                cc_next = {r[15], r == 16'd0,
                           !(src_reg[15] ^ dst_reg[15]) && (dst_reg[15] ^ r[15]), sum17[16]};
            end
            OP_SUB: begin
                r = dst_reg - src_reg;
                cc_next = {r[15], r == 16'd0,
                           (src_reg[15] ^ dst_reg[15]) && !(src_reg[15] ^ r[15]),
                           dst_reg < src_reg};
            end
            OP_BIT: begin
                wr = 1'b0;
                t = ss & ds;
                cc_next = {|(t & h), ~|t, 1'b0, fc};
            end
            OP_BIC: begin
                r = ~ss & ds & m;
                cc_next = {|(r & h), ~|r, 1'b0, fc};
            end
            OP_BIS: begin
                r = ss | ds;
                cc_next = {|(r & h), ~|r, 1'b0, fc};
            end
            OP_XOR: begin
                r = src_reg ^ dst_reg;
                cc_next = {r[15], r == 16'd0, 1'b0, fc};
            end
            OP_MUL: begin
                r = prod[31:16]; rl = prod[15:0]; wl = 1'b1;
                cc_next = {prod[31], prod == 32'd0, 1'b0,
                           !((prod[31:15] == 17'd0) || (prod[31:15] == 17'h1FFFF))};
            end
            OP_DIV: begin
                wr = 1'b0;
                if (src_reg == 16'd0) begin
                    cc_next = {fn, fz, 2'b11};
                end else if (qovf) begin
                    cc_next = {fn, fz, 2'b10};
                end else begin
                    r = q16; rl = r16; wr = 1'b1; wl = 1'b1;
                    cc_next = {q16[15], q16 == 16'd0, fv, 1'b0};
                end
            end
            OP_ASH: begin
                if (c6[5]) begin
                    n = ~src_reg[4:0];
                    x = {{16{dst_reg[15]}}, dst_reg};
                    x = $signed(x) >>> n;
                    cc_next[FC] = x[0];
                    x = $signed(x) >>> 1;
                    r = x[15:0];
                    cc_next[FV] = 1'b0;
                end else if (c6 == 6'd0) begin
                    r = dst_reg;
                    cc_next[FV] = 1'b0; cc_next[FC] = 1'b0;
                end else begin
                    x = {16'd0, dst_reg} << c6[4:0];
                    r = x[15:0];
                    cc_next[FC] = (c6 <= 6'd16) && x[16];
                    mk = (c6 >= 6'd15) ? 16'hFFFF : (16'hFFFF << (5'd15 - c6[4:0]));
                    t = dst_reg & mk;
                    cc_next[FV] = !((t == 16'd0) || (t == mk)) || (dst_reg[15] ^ r[15]);
                end
                cc_next[FN] = r[15];
                cc_next[FZ] = r == 16'd0;
            end
            OP_ASHC: begin
                x = {dst_reg, dl_reg};
                wl = 1'b1;
                if (c6 == 6'h20) begin
                    cc_next[FV] = 1'b0; cc_next[FC] = x[31];
                    x = {32{x[31]}};
                end else if (c6[5]) begin
                    n = ~src_reg[4:0];
                    x = $signed(x) >>> n;
                    cc_next[FC] = x[0];
                    x = $signed(x) >>> 1;
                end else if (c6 == 6'd0) begin
                    cc_next[FV] = 1'b0; cc_next[FC] = 1'b0;
                end else begin
                    x = x << (c6[4:0] - 5'd1);
                    cc_next[FC] = x[31];
                    x = x << 1;
                    cc_next[FV] = dst_reg[15] ^ x[31];
                end
                r = x[31:16]; rl = x[15:0];
                cc_next[FN] = x[31];
                cc_next[FZ] = x == 32'd0;
            end
            OP_CCC: begin wr = 1'b0; cc_next = cc_reg & ~src_reg[3:0]; end
            OP_SCC: begin wr = 1'b0; cc_next = cc_reg | src_reg[3:0]; end
            OP_BR:   begin wr = 1'b0; br = 1'b1; end
            OP_BNE:  begin wr = 1'b0; br = !fz; end
            OP_BEQ:  begin wr = 1'b0; br = fz; end
            OP_BPL:  begin wr = 1'b0; br = !fn; end
            OP_BMI:  begin wr = 1'b0; br = fn; end
            OP_BVC:  begin wr = 1'b0; br = !fv; end
            OP_BVS:  begin wr = 1'b0; br = fv; end
            OP_BCC:  begin wr = 1'b0; br = !fc; end
            OP_BCS:  begin wr = 1'b0; br = fc; end
            OP_BGE:  begin wr = 1'b0; br = fn == fv; end
            OP_BLT:  begin wr = 1'b0; br = fn != fv; end
            OP_BGT:  begin wr = 1'b0; br = !(fz || (fn != fv)); end
            OP_BLE:  begin wr = 1'b0; br = fz || (fn != fv); end
            OP_BHI:  begin wr = 1'b0; br = !fc && !fz; end
            OP_BLOS: begin wr = 1'b0; br = fc || fz; end
            default: wr = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg   <= '0;
            full_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                cc_reg   <= cc_next;
                full_reg <= 1'b1;
            end else if (cmd.out_take) begin
                full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            m_result       <= wr ? r : 16'd0;
            m_result_low   <= wl ? rl : 16'd0;
            m_write_result <= wr;
            m_write_low    <= wl;
            m_flags        <= cc_next;
            m_branch_taken <= br;
        end
    end

    assign sts.is_div   = (op_reg == OP_DIV);
    assign sts.out_full = full_reg;

endmodule

// ===== rtl/mac_ctrl.sv =====
// ----------------------------------------------------------------------------
// mac_ctrl
// Sequencer: capture, execute or run divide iterations, hold the result.
// ----------------------------------------------------------------------------
module mac_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                m_ready,
    input  mac_pkg::mac_sts_t   sts,
    output mac_pkg::mac_cmd_t   cmd
);
    import mac_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_free;

    assign out_free = !sts.out_full || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        cmd.out_take  = sts.out_full && m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.is_div && cnt_reg == '0) begin
                    cmd.div_start = 1'b1;
                    cnt_next      = CNT_W'(DIV_STEPS);
                    state_next    = ST_DIV;
                end else if (out_free) begin
                    cmd.exec   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_EXEC;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= (state_reg == ST_DIV && cnt_reg == CNT_W'(1)) ? CNT_W'(DIV_STEPS)
                                                                       : cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_step_only_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> state_reg == ST_DIV) else $error("div step outside DIV");
    a_no_load_and_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load && cmd.exec)) else $error("load and exec together");
    a_exec_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> (!sts.out_full || m_ready)) else $error("output overwritten");
`endif

endmodule

// ===== rtl/minicomputer_alu_condition_codes_core.sv =====
// ----------------------------------------------------------------------------
// minicomputer_alu_condition_codes_core
// PDP-11 style ALU with persistent N/Z/V/C condition codes.
// ----------------------------------------------------------------------------
// Input channel s_*: one operation per transfer (op, byte_mode, src, dst,
// dst_low). Output channel m_*: one result per input (result, result_low,
// write flags, new flags, branch_taken).
// Every op but DIV is computed in the EXEC state and registered into the output;
// DIV first runs the 32-step bit-serial restoring divider in the DIV state.
// A new input is accepted only in IDLE, after the previous op has executed.
// The result sits in an output register; the next item is taken while it
// waits, and execution stalls only if the previous result is still held.
// Reset (aresetn low, synchronous) clears the flags, empties the output
// register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module minicomputer_alu_condition_codes_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [5:0]  s_op,
    input  logic        s_byte_mode,
    input  logic [15:0] s_src,
    input  logic [15:0] s_dst,
    input  logic [15:0] s_dst_low,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_result,
    output logic [15:0] m_result_low,
    output logic        m_write_result,
    output logic        m_write_low,
    output logic [3:0]  m_flags,
    output logic        m_branch_taken
);
    import mac_pkg::*;

    mac_cmd_t cmd;
    mac_sts_t sts;

    mac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mac_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_op           (s_op),
        .s_byte_mode    (s_byte_mode),
        .s_src          (s_src),
        .s_dst          (s_dst),
        .s_dst_low      (s_dst_low),
        .m_result       (m_result),
        .m_result_low   (m_result_low),
        .m_write_result (m_write_result),
        .m_write_low    (m_write_low),
        .m_flags        (m_flags),
        .m_branch_taken (m_branch_taken)
    );

    assign m_valid = sts.out_full;

endmodule

// ===== tb/alu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_checker
// Watches both channels of the ALU core, predicts each result and the
// condition codes it leaves behind, and compares result transfers in order.
// ----------------------------------------------------------------------------
module alu_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [5:0]  s_op,
    input  logic        s_byte_mode,
    input  logic [15:0] s_src,
    input  logic [15:0] s_dst,
    input  logic [15:0] s_dst_low,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_result,
    input  logic [15:0] m_result_low,
    input  logic        m_write_result,
    input  logic        m_write_low,
    input  logic [3:0]  m_flags,
    input  logic        m_branch_taken,
    output int          errors,
    output int          pending,
    output int          results_seen
);
    import mac_pkg::*;

    typedef struct packed {
        logic [15:0] result;
        logic [15:0] result_low;
        logic        write_result;
        logic        write_low;
        logic [3:0]  flags;
        logic        branch_taken;
    } alu_out_t;

    alu_out_t   expected_q[$];
    logic [3:0] ccodes;

    function automatic logic [15:0] asr16(logic [15:0] x, int k);
        if (k > 15) k = 15;
        return 16'($signed(x) >>> k);
    endfunction

    function automatic logic [31:0] asr32(logic [31:0] x, int k);
        if (k > 31) k = 31;
        return 32'($signed(x) >>> k);
    endfunction

    function automatic alu_out_t predict_alu(logic [5:0] op, logic bmode,
                                             logic [15:0] s, logic [15:0] d,
                                             logic [15:0] dl);
        alu_out_t o;
        logic bf, wr, wl, br, cin, fn, fz, fv, fc;
        logic [15:0] m, h, ds, ss, r, rl, t, mk;
        logic [16:0] sum;
        logic [31:0] x;
        longint p, dv, dvs, q, rem;
        int n;
        bf = bmode && ((op <= OP_SBC && op != OP_SWAB) || op == OP_MOV || op == OP_CMP
                       || op == OP_BIT || op == OP_BIC || op == OP_BIS);
        m = bf ? 16'h00FF : 16'hFFFF;
        h = bf ? 16'h0080 : 16'h8000;
        ds = d & m;
        ss = s & m;
        fn = ccodes[FN]; fz = ccodes[FZ]; fv = ccodes[FV]; fc = ccodes[FC];
        cin = fc;
        r = '0; rl = '0; wr = 1'b1; wl = 1'b0; br = 1'b0;
        case (op)
            OP_CLR: begin
                r = 0; ccodes = 4'b0100;
            end
            OP_COM: begin
                r = ~ds & m; ccodes[FV] = 0; ccodes[FC] = 1;
            end
            OP_INC: begin
                r = (ds + 1) & m; ccodes[FV] = (ds == h - 1);
            end
            OP_DEC: begin
                r = (ds - 1) & m; ccodes[FV] = (ds == h);
            end
            OP_NEG: begin
                r = (-ds) & m; ccodes[FV] = (r == h); ccodes[FC] = (r != 0);
            end
            OP_TST: begin
                wr = 0; r = ds; ccodes[FV] = 0; ccodes[FC] = 0;
            end
            OP_ASR, OP_ASL, OP_ROR, OP_ROL: begin
                if (op == OP_ASR) begin
                    r = (ds >> 1) | (ds & h); ccodes[FC] = ds[0];
                end else if (op == OP_ASL) begin
                    r = (ds << 1) & m; ccodes[FC] = |(ds & h);
                end else if (op == OP_ROR) begin
                    r = (ds >> 1) | (cin ? h : 16'h0); ccodes[FC] = ds[0];
                end else begin
                    r = ((ds << 1) & m) | 16'(cin); ccodes[FC] = |(ds & h);
                end
                ccodes[FV] = (|(r & h)) != ccodes[FC];
            end
            OP_SWAB: begin
                r = {d[7:0], d[15:8]};
                ccodes = {r[7], r[7:0] == 0, 2'b00};
            end
            OP_ADC: begin
                r = (ds + cin) & m;
                ccodes[FV] = (ds == h - 1) && cin; ccodes[FC] = (ds == m) && cin;
            end
            OP_SBC: begin
                r = (ds - cin) & m;
                ccodes[FV] = (ds == h); ccodes[FC] = (ds == 0) && cin;
            end
            OP_SXT: begin
                r = fn ? 16'hFFFF : 16'h0; ccodes[FZ] = !fn; ccodes[FV] = 0;
            end
            OP_MOV: begin
                r = bf ? {{8{ss[7]}}, ss[7:0]} : s;
                ccodes[FN] = |(ss & h); ccodes[FZ] = (ss == 0); ccodes[FV] = 0;
            end
            OP_CMP: begin
                wr = 0; t = (ss - ds) & m; r = t;
                ccodes[FV] = (|((ss ^ ds) & h)) && !(|((ds ^ t) & h));
                ccodes[FC] = ss < ds;
            end
            OP_ADD: begin
                sum = s + d; r = sum[15:0];
                ccodes[FV] = !(s[15] ^ d[15]) && (d[15] ^ r[15]); ccodes[FC] = sum[16];
            end
            OP_SUB: begin
                r = d - s;
                ccodes[FV] = (s[15] ^ d[15]) && !(s[15] ^ r[15]); ccodes[FC] = d < s;
            end
            OP_BIT: begin
                wr = 0; r = ss & ds; ccodes[FV] = 0;
            end
            OP_BIC: begin
                r = ~ss & ds & m; ccodes[FV] = 0;
            end
            OP_BIS: begin
                r = ss | ds; ccodes[FV] = 0;
            end
            OP_XOR: begin
                r = s ^ d; ccodes[FV] = 0;
            end
            OP_MUL: begin
                p = longint'($signed(d)) * longint'($signed(s));
                {r, rl} = 32'(p); wl = 1;
                ccodes = {p < 0, p == 0, 1'b0, (p > 32767 || p < -32768)};
            end
            OP_DIV: begin
                dv = longint'($signed({d, dl}));
                wr = 0;
                if (s == 0) begin
                    ccodes[FV] = 1; ccodes[FC] = 1;
                end else begin
                    dvs = longint'($signed(s));
                    q = dv / dvs; rem = dv % dvs;
                    if (q < -32768 || q > 32767) begin
                        ccodes[FV] = 1; ccodes[FC] = 0;
                    end else begin
                        r = 16'(q); rl = 16'(rem); wr = 1; wl = 1;
                        ccodes[FN] = q < 0; ccodes[FZ] = q == 0; ccodes[FC] = 0;
                    end
                end
            end
            OP_ASH: begin
                if (s[5]) begin
                    n = 32 - int'(s[4:0]);
                    ccodes[FC] = asr16(d, n - 1) & 1;
                    r = asr16(d, n); ccodes[FV] = 0;
                end else if (s[5:0] == 0) begin
                    r = d; ccodes[FV] = 0; ccodes[FC] = 0;
                end else begin
                    n = s[5:0];
                    r = (n >= 16) ? 16'h0 : 16'(d << n);
                    mk = (n >= 15) ? 16'hFFFF : 16'(16'hFFFF << (15 - n));
                    t = d & mk;
                    ccodes[FV] = !(t == 0 || t == mk) || (d[15] ^ r[15]);
                    ccodes[FC] = (n <= 16) && (((d >> (16 - n)) & 1) != 0);
                end
                ccodes[FN] = r[15]; ccodes[FZ] = (r == 0);
            end
            OP_ASHC: begin
                x = {d, dl};
                if (s[5:0] == 6'h20) begin
                    ccodes[FV] = 0; ccodes[FC] = x[31]; x = {32{x[31]}};
                end else if (s[5]) begin
                    n = 32 - int'(s[4:0]);
                    ccodes[FC] = asr32(x, n - 1) & 1;
                    x = asr32(x, n);
                end else if (s[5:0] == 0) begin
                    ccodes[FV] = 0; ccodes[FC] = 0;
                end else begin
                    n = s[5:0];
                    ccodes[FC] = |((x << (n - 1)) & 32'h8000_0000);
                    x = x << n;
                    ccodes[FV] = d[15] != x[31];
                end
                {r, rl} = x; wl = 1;
                ccodes[FN] = x[31]; ccodes[FZ] = (x == 0);
            end
            OP_CCC: begin
                wr = 0; ccodes = ccodes & ~s[3:0];
            end
            OP_SCC: begin
                wr = 0; ccodes = ccodes | s[3:0];
            end
            OP_BR:   begin wr = 0; br = 1; end
            OP_BNE:  begin wr = 0; br = !fz; end
            OP_BEQ:  begin wr = 0; br = fz; end
            OP_BPL:  begin wr = 0; br = !fn; end
            OP_BMI:  begin wr = 0; br = fn; end
            OP_BVC:  begin wr = 0; br = !fv; end
            OP_BVS:  begin wr = 0; br = fv; end
            OP_BCC:  begin wr = 0; br = !fc; end
            OP_BCS:  begin wr = 0; br = fc; end
            OP_BGE:  begin wr = 0; br = (fn == fv); end
            OP_BLT:  begin wr = 0; br = (fn != fv); end
            OP_BGT:  begin wr = 0; br = !(fz || fn != fv); end
            OP_BLE:  begin wr = 0; br = fz || fn != fv; end
            OP_BHI:  begin wr = 0; br = !fc && !fz; end
            OP_BLOS: begin wr = 0; br = fc || fz; end
            default: wr = 0;
        endcase
        // N/Z from the byte- or word-sized value for the plain ALU group
        if (op <= OP_SBC && op != OP_SWAB && op != OP_CLR
            || (op >= OP_CMP && op <= OP_XOR)) begin
            ccodes[FN] = |(r & h); ccodes[FZ] = ((r & m) == 0);
        end
        o.result       = wr ? r : 16'h0;
        o.result_low   = wl ? rl : 16'h0;
        o.write_result = wr;
        o.write_low    = wl;
        o.flags        = ccodes;
        o.branch_taken = br;
        return o;
    endfunction

    always @(posedge aclk) begin
        alu_out_t want;
        if (!aresetn) begin
            ccodes = 4'h0;
            expected_q.delete();
            errors <= 0;
            results_seen <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_q.push_back(predict_alu(s_op, s_byte_mode, s_src, s_dst, s_dst_low));
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0) begin
                    $display("%0t: result transfer with nothing expected", $time);
                    errors <= errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want !== {m_result, m_result_low, m_write_result, m_write_low,
                                  m_flags, m_branch_taken}) begin
                        $display("%0t: mismatch expected res=%h low=%h wr=%b wl=%b f=%h br=%b",
                                 $time, want.result, want.result_low, want.write_result,
                                 want.write_low, want.flags, want.branch_taken);
                        $display("%0t:          actual res=%h low=%h wr=%b wl=%b f=%h br=%b",
                                 $time, m_result, m_result_low, m_write_result,
                                 m_write_low, m_flags, m_branch_taken);
                        errors <= errors + 1;
                    end
                end
            end
        end
        pending <= expected_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random ALU operations into the core with random
// idling on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import mac_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [5:0]  s_op = '0;
    logic        s_byte_mode = 0;
    logic [15:0] s_src = '0;
    logic [15:0] s_dst = '0;
    logic [15:0] s_dst_low = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [15:0] m_result;
    logic [15:0] m_result_low;
    logic        m_write_result;
    logic        m_write_low;
    logic [3:0]  m_flags;
    logic        m_branch_taken;
    int          errors;
    int          pending;
    int          results_seen;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          sent;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    minicomputer_alu_condition_codes_core dut (.*);

    alu_checker checker_i (.*);

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_op(logic [5:0] op, logic bm, logic [15:0] s, logic [15:0] d,
                           logic [15:0] dl);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1; s_op <= op; s_byte_mode <= bm;
        s_src <= s; s_dst <= d; s_dst_low <= dl;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            4: return 16'($urandom_range(255)) ^ {16{$urandom_range(1) == 1}};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_op();
        logic [5:0]  op;
        logic [15:0] s, d, dl;
        op = ($urandom_range(19) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(42));
        s = pick_word(); d = pick_word(); dl = pick_word();
        if (op == OP_DIV && $urandom_range(2) != 0) begin
            // keep most divides in range
            s = 16'($urandom); d = {16{dl[15]}};
        end
        send_op(op, 1'($urandom), s, d, dl);
    endtask

    initial begin
        #2000000;
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        int ph;
        send_idle_pct = 0; recv_idle_pct = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send_op(OP_CLR, 0, 0, 16'hFFFF, 0);
        send_op(OP_NEG, 1, 0, 16'h0080, 0);
        send_op(OP_NEG, 0, 0, 16'h8000, 0);
        send_op(OP_INC, 0, 0, 16'h7FFF, 0);
        send_op(OP_MOV, 1, 16'h0080, 0, 0);
        send_op(OP_SXT, 0, 0, 0, 0);
        send_op(OP_SWAB, 1, 0, 16'h80FF, 0);
        send_op(OP_ADD, 0, 16'hFFFF, 16'h0001, 0);
        send_op(OP_ADC, 1, 0, 16'h00FF, 0);
        send_op(OP_MUL, 0, 16'h8000, 16'h8000, 0);
        send_op(OP_MUL, 0, 16'h0100, 16'h0080, 0);
        send_op(OP_DIV, 0, 16'h0000, 16'h1234, 16'h5678);
        send_op(OP_DIV, 0, 16'h0001, 16'h0001, 16'h0000);
        send_op(OP_DIV, 0, 16'hFFFF, 16'h8000, 16'h0000);
        send_op(OP_DIV, 0, 16'h0007, 16'hFFFF, 16'hFFF0);
        send_op(OP_ASH, 0, 16'h0020, 16'h8001, 0);
        send_op(OP_ASH, 0, 16'h0010, 16'h0001, 0);
        send_op(OP_ASH, 0, 16'h0011, 16'hFFFF, 0);
        send_op(OP_ASHC, 0, 16'h0020, 16'h8000, 16'h0001);
        send_op(OP_ASHC, 0, 16'h003F, 16'h0000, 16'h0003);
        send_op(OP_ASHC, 0, 16'h001F, 16'h4000, 16'h0001);
        send_op(OP_SCC, 0, 16'h000F, 0, 0);
        send_op(OP_BLE, 0, 0, 0, 0);
        send_op(OP_CCC, 0, 16'h000F, 0, 0);
        send_op(6'd63, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 86 : 0;
            recv_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 25 : 0;
            repeat (510) random_op();
        end
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("covered %0d operations and %0d results under three idling mixes",
                 sent, results_seen);
        if (errors == 0 && pending == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mac_pkg.sv
rtl/mac_datapath.sv
rtl/mac_ctrl.sv
rtl/minicomputer_alu_condition_codes_core.sv
tb/alu_checker.sv
tb/testbench.sv
